// ===== rtl/core/ccmm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccmm_pkg
// Shared types and constants of the channel mode manager.
// ----------------------------------------------------------------------------
package ccmm_pkg;

  localparam int NUM_CHANNELS = 4;
  localparam int NUM_USERS    = 8;
  localparam int COUNT_BITS   = 8;
  localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int USR_W        = (NUM_USERS > 1) ? $clog2(NUM_USERS) : 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [3:0] {
    K_TICK = 4'd0, K_REQUEST = 4'd1, K_GET_REQ = 4'd2, K_GET_CUR = 4'd3,
    K_ALLOWED = 4'd4, K_BUS_MODE = 4'd5, K_DCM_ACT = 4'd6, K_DCM_INACT = 4'd7,
    K_DCM_PASS = 4'd8, K_LIMIT_CH = 4'd9, K_LIMIT_ECU = 4'd10,
    K_PREVENT = 4'd11, K_INHIBIT = 4'd12
  } kind_t;

  localparam logic [1:0] ST_OK = 2'd0, ST_BAD_USER = 2'd1, ST_BAD_CH = 2'd2,
                         ST_BAD_MODE = 2'd3;
  localparam logic [1:0] M_NONE = 2'd0, M_SILENT = 2'd1, M_FULL = 2'd2,
                         M_INVALID = 2'd3;
  localparam logic [1:0] F_NONE = 2'd0, F_PEND = 2'd1, F_FULL = 2'd2,
                         F_SILENT = 2'd3;
  localparam logic [1:0] CFG_MAP = 2'd0, CFG_WAKE = 2'd1, CFG_DELAY = 2'd2,
                         CFG_TMO = 2'd3;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] mode_out;
    logic [1:0] inhibition;
    logic [2:0] channel_out;
    logic [1:0] channel_fsm;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [3:0] kind;
    logic [3:0] user;
    logic [2:0] channel;
    logic [1:0] mode;
    logic       flag;
  } item_t;

  // controller -> datapath
  typedef struct packed {
    logic          exec;   // run non-tick item
    logic          step;   // step channel ch
    logic [CH_W-1:0] ch;
    logic          last;
  } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/ccmm_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccmm_if
// Valid/ready channel carrying a generic payload.
// ----------------------------------------------------------------------------
interface ccmm_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ccmm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccmm_ctrl
// Sequencer: takes an item, issues exec or one step per channel.
// ----------------------------------------------------------------------------
module ccmm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic           in_is_tick,
  output logic                in_ready,
  input  wire logic           res_free,
  output ccmm_pkg::cmd_t      cmd
);
  typedef enum logic [2:0] {S_IDLE = 3'b001, S_EXEC = 3'b010, S_TICK = 3'b100} state_t;
  state_t state_r, state_nxt;
  logic [ccmm_pkg::CH_W-1:0] ch_r, ch_nxt;
  localparam logic [ccmm_pkg::CH_W-1:0] CH_LAST = ccmm_pkg::CH_W'(ccmm_pkg::NUM_CHANNELS - 1);

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = in_is_tick ? S_TICK : S_EXEC;
          ch_nxt    = '0;
        end
      end
      S_EXEC: begin
        if (res_free) begin
          cmd.exec  = 1'b1;
          cmd.last  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_TICK: begin
        if (res_free) begin
          cmd.step = 1'b1;
          cmd.ch   = ch_r;
          cmd.last = (ch_r == CH_LAST);
          if (ch_r == CH_LAST) state_nxt = S_IDLE;
          else ch_nxt = ch_r + 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ch_r    <= '0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/ccmm_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccmm_dp
// Channel/user state, config registers, result register.
// ----------------------------------------------------------------------------
module ccmm_dp (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_we,
  input  wire logic [1:0]      cfg_idx,
  input  wire logic [31:0]     cfg_data,
  input  wire logic            cap,
  input  wire ccmm_pkg::item_t item,
  input  wire ccmm_pkg::cmd_t  cmd,
  output logic                 res_free,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output ccmm_pkg::res_t       out_data
);
  localparam int NC = ccmm_pkg::NUM_CHANNELS;
  localparam int NU = ccmm_pkg::NUM_USERS;
  localparam int CB = ccmm_pkg::COUNT_BITS;

  logic [31:0] map_r, dly_r, tmo_r;
  logic [3:0]  wsup_r;
  ccmm_pkg::item_t item_r;
  logic [1:0] fsm_r [NC];
  logic [CB-1:0] cnt_r [NC];
  logic [NC-1:0] allow_r, winh_r, lim_r, dact_r, dpas_r;
  logic [1:0] umode_r [NU];
  logic ecu_r;
  logic vld_r;
  ccmm_pkg::res_t res_r;

  assign res_free  = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign out_data  = res_r;

  function automatic logic maps(logic [31:0] m, int u, int c);
    if (c >= 4 || 4 * u + c >= 32) return 1'b0;
    return m[4 * u + c];
  endfunction

  function automatic logic [CB-1:0] ld(logic [31:0] p, int c);
    logic [7:0] v;
    if (c >= 4) return '0;
    v = p[8 * c +: 8];
    if (CB >= 8) return CB'(v);
    return (v > 8'(ccmm_pkg::CNT_MAX)) ? ccmm_pkg::CNT_MAX : CB'(v);
  endfunction

  function automatic logic [1:0] fmode(logic [1:0] s);
    return (s == ccmm_pkg::F_FULL) ? ccmm_pkg::M_FULL :
           (s == ccmm_pkg::F_SILENT) ? ccmm_pkg::M_SILENT : ccmm_pkg::M_NONE;
  endfunction

  // per-channel request and next state (step)
  logic [1:0] req;
  logic [1:0] nfsm;
  logic [CB-1:0] ncnt;
  logic [1:0] cf;
  logic [CB-1:0] cc;
  logic ubad, cbad;
  logic [ccmm_pkg::CH_W-1:0] ich;
  logic [ccmm_pkg::USR_W-1:0] iu;
  logic [1:0] best;
  ccmm_pkg::res_t rx;

  assign ubad = 32'(item_r.user) >= NU;
  assign cbad = 32'(item_r.channel) >= NC;
  assign ich  = item_r.channel[ccmm_pkg::CH_W-1:0];
  assign iu   = item_r.user[ccmm_pkg::USR_W-1:0];

  always_comb begin
    req = ccmm_pkg::M_NONE;
    for (int u = 0; u < NU; u++)
      if (maps(map_r, u, int'(cmd.ch)) && umode_r[u] > req) req = umode_r[u];
    if (dact_r[cmd.ch] && req < ccmm_pkg::M_FULL) req = ccmm_pkg::M_FULL;
    if (dpas_r[cmd.ch] && req < ccmm_pkg::M_SILENT) req = ccmm_pkg::M_SILENT;
    if (ecu_r || lim_r[cmd.ch] || !allow_r[cmd.ch]) req = ccmm_pkg::M_NONE;
    cf = fsm_r[cmd.ch];
    cc = cnt_r[cmd.ch];
    nfsm = cf;
    ncnt = cc;
    case (cf)
      ccmm_pkg::F_NONE:
        if (req == ccmm_pkg::M_FULL) begin
          nfsm = ccmm_pkg::F_PEND; ncnt = ld(dly_r, int'(cmd.ch));
        end
      ccmm_pkg::F_PEND: begin
        if (cc != '0) ncnt = cc - 1'b1;
        else nfsm = ccmm_pkg::F_FULL;
        if (req == ccmm_pkg::M_NONE) nfsm = ccmm_pkg::F_NONE;
      end
      ccmm_pkg::F_FULL:
        if (req != ccmm_pkg::M_FULL) begin
          nfsm = ccmm_pkg::F_SILENT; ncnt = ld(tmo_r, int'(cmd.ch));
        end
      default:
        if (req == ccmm_pkg::M_FULL) nfsm = ccmm_pkg::F_FULL;
        else if (req == ccmm_pkg::M_NONE) begin
          if (cc != '0) ncnt = cc - 1'b1;
          else nfsm = ccmm_pkg::F_NONE;
        end
    endcase
    best = ccmm_pkg::M_NONE;
    for (int c = 0; c < NC; c++)
      if (maps(map_r, int'(item_r.user), c) && fmode(fsm_r[c]) > best)
        best = fmode(fsm_r[c]);
    rx = '0;
    rx.last = 1'b1;
    if (item_r.kind >= 4'd1 && item_r.kind <= 4'd3 && ubad)
      rx.status = ccmm_pkg::ST_BAD_USER;
    else if (((item_r.kind >= 4'd4 && item_r.kind <= 4'd9) ||
              item_r.kind == ccmm_pkg::K_PREVENT || item_r.kind == ccmm_pkg::K_INHIBIT)
             && cbad)
      rx.status = ccmm_pkg::ST_BAD_CH;
    else if ((item_r.kind == ccmm_pkg::K_REQUEST || item_r.kind == ccmm_pkg::K_BUS_MODE)
             && item_r.mode == ccmm_pkg::M_INVALID)
      rx.status = ccmm_pkg::ST_BAD_MODE;
    else if (item_r.kind == ccmm_pkg::K_GET_REQ) rx.mode_out = umode_r[iu];
    else if (item_r.kind == ccmm_pkg::K_GET_CUR) rx.mode_out = best;
    else if (item_r.kind == ccmm_pkg::K_INHIBIT)
      rx.inhibition = {lim_r[ich] | ecu_r, winh_r[ich]};
  end

  logic ok;
  assign ok = (rx.status == ccmm_pkg::ST_OK);

  always_ff @(posedge clk) begin
    if (cap) item_r <= item;
    if (cfg_we) begin
      unique case (cfg_idx)
        ccmm_pkg::CFG_MAP:   map_r  <= cfg_data;
        ccmm_pkg::CFG_WAKE:  wsup_r <= cfg_data[3:0];
        ccmm_pkg::CFG_DELAY: dly_r  <= cfg_data;
        ccmm_pkg::CFG_TMO:   tmo_r  <= cfg_data;
        default: ;
      endcase
    end
    if (cmd.step) begin
      fsm_r[cmd.ch] <= nfsm;
      cnt_r[cmd.ch] <= ncnt;
      res_r <= '{status: ccmm_pkg::ST_OK, mode_out: fmode(nfsm),
                 inhibition: {lim_r[cmd.ch] | ecu_r, winh_r[cmd.ch]},
                 channel_out: 3'(cmd.ch), channel_fsm: nfsm, last: cmd.last};
    end
    if (cmd.exec) begin
      res_r <= rx;
      if (ok) begin
        case (item_r.kind)
          ccmm_pkg::K_REQUEST: umode_r[iu] <= item_r.mode;
          ccmm_pkg::K_ALLOWED: allow_r[ich] <= item_r.flag;
          ccmm_pkg::K_BUS_MODE:
            fsm_r[ich] <= (item_r.mode == ccmm_pkg::M_NONE) ? ccmm_pkg::F_NONE :
                          (item_r.mode == ccmm_pkg::M_SILENT) ? ccmm_pkg::F_SILENT :
                          ccmm_pkg::F_FULL;
          ccmm_pkg::K_DCM_ACT: begin dact_r[ich] <= 1'b1; dpas_r[ich] <= 1'b0; end
          ccmm_pkg::K_DCM_INACT: begin dact_r[ich] <= 1'b0; dpas_r[ich] <= 1'b0; end
          ccmm_pkg::K_DCM_PASS: dpas_r[ich] <= item_r.flag;
          ccmm_pkg::K_LIMIT_CH: lim_r[ich] <= item_r.flag;
          ccmm_pkg::K_LIMIT_ECU: ecu_r <= item_r.flag;
          ccmm_pkg::K_PREVENT: winh_r[ich] <= item_r.flag;
          default: ;
        endcase
      end
    end
    if (!rst_n) begin
      map_r <= '0; dly_r <= '0; tmo_r <= '0; wsup_r <= '0;
      for (int c = 0; c < NC; c++) begin fsm_r[c] <= '0; cnt_r[c] <= '0; end
      for (int u = 0; u < NU; u++) umode_r[u] <= '0;
      allow_r <= '1; winh_r <= '0; lim_r <= '0; dact_r <= '0; dpas_r <= '0;
      ecu_r <= 1'b0;
      vld_r <= 1'b0;
    end else if (cmd.step || cmd.exec) vld_r <= 1'b1;
    else if (out_ready) vld_r <= 1'b0;
  end

  // wake-up support mask is stored only
  logic unused_wsup;
  assign unused_wsup = ^wsup_r;
endmodule
`default_nettype wire

// ===== rtl/core/comm_channel_mode_manager.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// comm_channel_mode_manager
// Per-user requested modes and per-channel communication state machines.
// ----------------------------------------------------------------------------
// channel | dir | payload
// in_     | in  | kind, user, channel, mode, flag
// out_    | out | status, mode_out, inhibition, channel_out, channel_fsm, last
// cfg_    | in  | we, idx, data (4 registers)
//
// A non-tick item is accepted, then gives one result beat. A tick has the
// sequencer step one channel per cycle, while the output is not stalled, through
// the shared request-resolve and state logic, one beat each. Reset is synchronous;
// all state but the captured item and result data returns to defaults at once.
// Output stalls hold the sequencer; the result register frees as taken.
// ----------------------------------------------------------------------------
module comm_channel_mode_manager (
  input  wire logic        clk,
  input  wire logic        rst_n,
  ccmm_if.sink             in_ch,
  ccmm_if.source           out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_idx,
  input  wire logic [31:0] cfg_data
);
  ccmm_pkg::cmd_t cmd;
  logic res_free;
  logic in_ready;
  ccmm_pkg::item_t item;

  assign item = in_ch.data;
  assign in_ch.ready = in_ready;

  ccmm_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid   (in_ch.valid),
    .in_is_tick (item.kind == ccmm_pkg::K_TICK),
    .in_ready,
    .res_free,
    .cmd
  );

  ccmm_dp u_dp (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_data,
    .cap       (in_ch.valid && in_ready),
    .item,
    .cmd,
    .res_free,
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
  );
endmodule
`default_nettype wire

// ===== tb/sv/ccmm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccmm_checker
// Watches the item and result channels of the mode manager, predicts every
// result beat from accepted items and configuration writes, and counts
// mismatches against the predicted beats in order.
// ----------------------------------------------------------------------------
module ccmm_checker
  import ccmm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  item_t       in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  res_t        out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  logic [31:0] map_r, wake_r, delay_r, tmo_r;
  logic [1:0]  fsm_q [NUM_CHANNELS];
  logic [1:0]  cmode_q [NUM_CHANNELS];
  logic [COUNT_BITS-1:0] cnt_q [NUM_CHANNELS];
  logic        allowed_q [NUM_CHANNELS];
  logic        inhib_q [NUM_CHANNELS];
  logic        limit_q [NUM_CHANNELS];
  logic        dact_q [NUM_CHANNELS];
  logic        dpas_q [NUM_CHANNELS];
  logic [1:0]  umode_q [NUM_USERS];
  logic        ecu_lim_q;
  res_t        expected_beats [$];

  assign pending = expected_beats.size();

  function automatic logic user_drives(int u, int c);
    int b;
    b = 4 * u + c;
    if (c >= 4 || b >= 32) return 1'b0;
    return map_r[b];
  endfunction

  function automatic logic [COUNT_BITS-1:0] count_of(logic [31:0] packed_v, int c);
    logic [7:0] v;
    v = packed_v[8*c +: 8];
    return (v > CNT_MAX) ? CNT_MAX : v[COUNT_BITS-1:0];
  endfunction

  function automatic logic [1:0] inhib_of(int c);
    return {limit_q[c] | ecu_lim_q, inhib_q[c]};
  endfunction

  task automatic advance_channel(int c);
    logic [1:0] req;
    req = M_NONE;
    for (int u = 0; u < NUM_USERS; u++)
      if (user_drives(u, c) && umode_q[u] > req) req = umode_q[u];
    if (dact_q[c] && req < M_FULL) req = M_FULL;
    if (dpas_q[c] && req < M_SILENT) req = M_SILENT;
    if (ecu_lim_q || limit_q[c] || !allowed_q[c]) req = M_NONE;
    case (fsm_q[c])
      F_NONE: begin
        if (req == M_FULL) begin
          fsm_q[c] = F_PEND;
          cnt_q[c] = count_of(delay_r, c);
        end
      end
      F_PEND: begin
        if (cnt_q[c] > 0) cnt_q[c]--;
        else fsm_q[c] = F_FULL;
        if (req == M_NONE) fsm_q[c] = F_NONE;
      end
      F_FULL: begin
        if (req != M_FULL) begin
          fsm_q[c] = F_SILENT;
          cnt_q[c] = count_of(tmo_r, c);
        end
      end
      default: begin
        if (req == M_FULL) fsm_q[c] = F_FULL;
        else if (req == M_NONE) begin
          if (cnt_q[c] > 0) cnt_q[c]--;
          else fsm_q[c] = F_NONE;
        end
      end
    endcase
    cmode_q[c] = (fsm_q[c] == F_FULL) ? M_FULL : (fsm_q[c] == F_SILENT) ? M_SILENT : M_NONE;
  endtask

  task automatic predict_item(item_t it);
    res_t r;
    logic ubad, cbad, chk;
    logic [1:0] best;
    logic [USR_W-1:0] ui;
    logic [CH_W-1:0] ci;
    r = '0;
    if (it.kind == K_TICK) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        advance_channel(c);
        r = '0;
        r.mode_out = cmode_q[c];
        r.inhibition = inhib_of(c);
        r.channel_out = 3'(c);
        r.channel_fsm = fsm_q[c];
        r.last = (c == NUM_CHANNELS - 1);
        expected_beats.push_back(r);
      end
      return;
    end
    r.last = 1'b1;
    ubad = it.user >= NUM_USERS;
    cbad = it.channel >= NUM_CHANNELS;
    ui = it.user[USR_W-1:0];
    ci = it.channel[CH_W-1:0];
    chk = (it.kind >= K_ALLOWED && it.kind <= K_LIMIT_CH) || it.kind == K_PREVENT ||
          it.kind == K_INHIBIT;
    if (it.kind >= K_REQUEST && it.kind <= K_GET_CUR && ubad) r.status = ST_BAD_USER;
    else if (chk && cbad) r.status = ST_BAD_CH;
    else if ((it.kind == K_REQUEST || it.kind == K_BUS_MODE) && it.mode == M_INVALID)
      r.status = ST_BAD_MODE;
    else begin
      case (it.kind)
        K_REQUEST:   umode_q[ui] = it.mode;
        K_GET_REQ:   r.mode_out = umode_q[ui];
        K_GET_CUR: begin
          best = M_NONE;
          for (int c = 0; c < NUM_CHANNELS; c++)
            if (user_drives(it.user, c) && cmode_q[c] > best) best = cmode_q[c];
          r.mode_out = best;
        end
        K_ALLOWED:   allowed_q[ci] = it.flag;
        K_BUS_MODE: begin
          cmode_q[ci] = it.mode;
          fsm_q[ci] = (it.mode == M_NONE) ? F_NONE :
                      (it.mode == M_SILENT) ? F_SILENT : F_FULL;
        end
        K_DCM_ACT: begin
          dact_q[ci] = 1'b1;
          dpas_q[ci] = 1'b0;
        end
        K_DCM_INACT: begin
          dact_q[ci] = 1'b0;
          dpas_q[ci] = 1'b0;
        end
        K_DCM_PASS:  dpas_q[ci] = it.flag;
        K_LIMIT_CH:  limit_q[ci] = it.flag;
        K_LIMIT_ECU: ecu_lim_q = it.flag;
        K_PREVENT:   inhib_q[ci] = it.flag;
        K_INHIBIT:   r.inhibition = inhib_of(it.channel);
        default: ;
      endcase
    end
    expected_beats.push_back(r);
  endtask

  always @(posedge clk) begin
    res_t exp_r;
    if (!rst_n) begin
      map_r <= '0; wake_r <= '0; delay_r <= '0; tmo_r <= '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        fsm_q[c] = F_NONE; cmode_q[c] = M_NONE; cnt_q[c] = '0;
        allowed_q[c] = 1'b1; inhib_q[c] = 1'b0; limit_q[c] = 1'b0;
        dact_q[c] = 1'b0; dpas_q[c] = 1'b0;
      end
      for (int u = 0; u < NUM_USERS; u++) umode_q[u] = M_NONE;
      ecu_lim_q = 1'b0;
      expected_beats.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_MAP:   map_r <= cfg_data;
          CFG_WAKE:  wake_r <= {28'd0, cfg_data[3:0]};
          CFG_DELAY: delay_r <= cfg_data;
          CFG_TMO:   tmo_r <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          if (fail_count < 10) $display("unexpected result beat %p", out_data);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_beats.pop_front();
          if (out_data !== exp_r) begin
            if (fail_count < 10)
              $display("mismatch at %0t: expected %p actual %p", $time, exp_r, out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
      // prediction after the compare: a beat taken at this edge belongs to an
      // earlier item, the new item's beats come out at later edges
      if (in_valid && in_ready) predict_item(in_data);
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the channel mode manager: directed items over every kind and
// error case, then mostly well-formed random traffic with several register
// settings; the checker predicts and compares all result beats.
// ----------------------------------------------------------------------------
module tb_top;
  import ccmm_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = '0;
  logic [31:0] cfg_data = '0;
  int          fail_count;
  int          pending;

  ccmm_if #(.T(item_t)) in_ch ();
  ccmm_if #(.T(res_t))  out_ch ();

  always #5 clk = ~clk;

  comm_channel_mode_manager dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  ccmm_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // Receiver: random stall before each beat, with stall-free stretches.
  bit no_stall = 1'b0;
  always @(posedge clk) begin
    int gap;
    if (rst_n) begin
      if (out_ch.ready && out_ch.valid) begin
        gap = no_stall ? 0 : $urandom_range(0, 18);
        if (gap != 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
          out_ch.ready <= 1'b1;
        end
      end else out_ch.ready <= 1'b1;
    end
  end

  bit no_gap = 1'b0;

  // One beat on the item channel; valid stays high across back-to-back beats.
  task automatic send_item(logic [3:0] k, logic [3:0] u, logic [2:0] ch,
                           logic [1:0] m, logic f);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= '{kind: k, user: u, channel: ch, mode: m, flag: f};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Drop valid and wait until the block has delivered every predicted beat.
  task automatic drain;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly meaningful traffic: valid users/channels/modes, ticks often.
  task automatic random_item;
    int sel;
    logic [3:0] k, u;
    logic [2:0] ch;
    logic [1:0] m;
    sel = $urandom_range(0, 99);
    u  = (sel < 90) ? 4'($urandom_range(0, NUM_USERS - 1)) : 4'($urandom_range(0, 15));
    ch = (sel < 90) ? 3'($urandom_range(0, NUM_CHANNELS - 1)) : 3'($urandom_range(0, 7));
    m  = (sel < 93) ? 2'($urandom_range(0, 2)) : 2'($urandom_range(0, 3));
    if (sel < 30) k = K_TICK;
    else if (sel < 50) k = K_REQUEST;
    else if (sel < 97) k = 4'($urandom_range(1, 12));
    else k = 4'($urandom_range(0, 15));
    // keep the limits mostly released so channels reach full communication
    send_item(k, u, ch, m,
              1'((k == K_LIMIT_ECU || k == K_LIMIT_CH) ? ($urandom_range(0, 4) == 0)
                                                        : $urandom_range(0, 1)));
  endtask

  initial begin
    logic [31:0] delays_v, tmo_v;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: defaults, then every kind and error case.
    send_item(K_TICK, 0, 0, M_NONE, 0);
    send_item(K_REQUEST, 15, 0, M_FULL, 0);
    send_item(K_GET_REQ, 8, 0, M_NONE, 0);
    send_item(K_GET_CUR, 9, 0, M_NONE, 0);
    send_item(K_REQUEST, 0, 0, M_INVALID, 0);
    send_item(K_BUS_MODE, 0, 7, M_INVALID, 0);
    send_item(K_BUS_MODE, 0, 1, M_INVALID, 0);
    send_item(K_ALLOWED, 0, 4, M_NONE, 1);
    send_item(K_INHIBIT, 0, 7, M_NONE, 0);
    send_item(4'd13, 0, 0, M_NONE, 0);
    send_item(4'd15, 15, 7, M_INVALID, 1);
    drain();
    write_reg(CFG_MAP, 32'hFFFF_FFFF);
    write_reg(CFG_WAKE, 32'hF);
    write_reg(CFG_DELAY, 32'h0001_FF02);
    write_reg(CFG_TMO, 32'hFF00_0301);
    send_item(K_REQUEST, 7, 0, M_FULL, 0);
    send_item(K_GET_REQ, 7, 0, M_NONE, 0);
    send_item(K_TICK, 0, 0, M_NONE, 0);
    send_item(K_TICK, 0, 0, M_NONE, 0);
    send_item(K_GET_CUR, 7, 0, M_NONE, 0);
    send_item(K_DCM_ACT, 0, 3, M_NONE, 0);
    send_item(K_DCM_PASS, 0, 2, M_NONE, 1);
    send_item(K_DCM_INACT, 0, 3, M_NONE, 0);
    send_item(K_PREVENT, 0, 1, M_NONE, 1);
    send_item(K_LIMIT_CH, 0, 2, M_NONE, 1);
    send_item(K_LIMIT_ECU, 0, 0, M_NONE, 1);
    send_item(K_INHIBIT, 0, 1, M_NONE, 0);
    send_item(K_BUS_MODE, 0, 3, M_SILENT, 0);
    send_item(K_TICK, 0, 0, M_NONE, 0);

    // Random phases, each under a new register setting; the first pause is
    // the hold-off until all predicted beats are back.
    for (int ph = 0; ph < 7; ph++) begin
      drain();
      case (ph)
        0: begin delays_v = '0; tmo_v = '0; end
        1: begin delays_v = 32'hFFFF_FFFF; tmo_v = 32'hFFFF_FFFF; end
        default: begin
          delays_v = {4{8'($urandom_range(0, 6))}} ^ {8'($urandom_range(0, 3)), 24'h0};
          tmo_v = {8'($urandom_range(0, 5)), 8'($urandom_range(0, 5)),
                   8'($urandom_range(0, 5)), 8'($urandom_range(0, 5))};
        end
      endcase
      write_reg(CFG_MAP, (ph == 0) ? 32'h0 : $urandom);
      write_reg(CFG_WAKE, $urandom_range(0, 15));
      write_reg(CFG_DELAY, delays_v);
      write_reg(CFG_TMO, tmo_v);
      no_gap   = (ph == 3);
      no_stall = (ph == 4);
      for (int i = 0; i < 50; i++) random_item();
    end
    drain();
    if (fail_count == 0 && pending == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/ccmm_pkg.sv
rtl/core/ccmm_if.sv
rtl/core/ccmm_ctrl.sv
rtl/core/ccmm_dp.sv
rtl/core/comm_channel_mode_manager.sv
tb/sv/ccmm_checker.sv
tb/sv/tb_top.sv
